@@ hdl/spsw_pkg.sv @@
// Shared types and constants for the stroke point smoother with width.
// No dependencies.
`default_nettype none
package spsw_pkg;
    localparam int unsigned IDX_SMOOTHING     = 0;
    localparam int unsigned IDX_DYNAMIC_WIDTH = 1;
    localparam int unsigned IDX_BASE_WIDTH    = 2;

    localparam logic [17:0] F_ONE = 18'd65536;
    localparam logic [17:0] F_MAX = 18'd131072;
    localparam logic [17:0] F_MIN = 18'd6554;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_SQRT,
        ST_FDIV,
        ST_WIDTH,
        ST_MUL2,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;      // shift new point into window
        logic sum_clr;   // start accumulation for emit offset
        logic sum_step;  // add one window tap
        logic div_start;
        logic div_step;
        logic sqrt_start;
        logic sqrt_step;
        logic fdiv_start;
        logic fdiv_step;
        logic wid_mul1;
        logic wid_mul2;
        logic out_load;  // capture finished word into output register
        logic commit;    // update previous point
        logic stroke_clr;
    } t_cmd;

    typedef struct packed {
        logic       sum_done;
        logic       div_done;
        logic       sqrt_done;
        logic       fdiv_done;
        logic       need_speed; // speed factor path taken
    } t_sts;
endpackage
`default_nettype wire

@@ hdl/spsw_ctrl.sv @@
// Controller for the stroke smoother: sequences window sums, divides, root, width multiplies and output.
// Depends on spsw_pkg.
`default_nettype none
module spsw_ctrl
    import spsw_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_fire,
    input  wire logic i_emit_any,   // this point causes at least one word
    input  wire logic i_more,       // more words pending after current one
    input  wire logic i_out_free,   // output register can be loaded
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_busy
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in_fire && i_emit_any) n_state = ST_SUM;
            ST_SUM:   if (i_sts.sum_done) n_state = ST_DIV;
            ST_DIV:   if (i_sts.div_done) n_state = i_sts.need_speed ? ST_SQRT : ST_WIDTH;
            ST_SQRT:  if (i_sts.sqrt_done) n_state = ST_FDIV;
            ST_FDIV:  if (i_sts.fdiv_done) n_state = ST_WIDTH;
            ST_WIDTH: n_state = ST_MUL2;
            ST_MUL2:  n_state = ST_OUT;
            ST_OUT:   if (i_out_free) n_state = i_more ? ST_SUM : ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.load = (r_state == ST_IDLE) && i_in_fire;
        o_cmd.sum_clr = (r_state == ST_IDLE && i_in_fire && i_emit_any)
            || (r_state == ST_OUT && i_out_free && i_more);
        unique case (r_state)
            ST_SUM: begin
                o_cmd.sum_step = 1'b1;
                o_cmd.div_start = i_sts.sum_done;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.sqrt_start = i_sts.div_done;
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                o_cmd.fdiv_start = i_sts.sqrt_done;
            end
            ST_FDIV:  o_cmd.fdiv_step = 1'b1;
            ST_WIDTH: o_cmd.wid_mul1 = 1'b1;
            ST_MUL2:  o_cmd.wid_mul2 = 1'b1;
            ST_OUT: begin
                o_cmd.out_load = i_out_free;
                o_cmd.commit = i_out_free;
                o_cmd.stroke_clr = i_out_free && !i_more;
            end
            default: ;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

    a_sum_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_fire && i_emit_any) |=> (r_state == ST_SUM))
        else $error("controller did not start window sum");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && !i_out_free) |=> (r_state == ST_OUT))
        else $error("controller left output state while blocked");
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_cmd.load)
        else $error("point loaded while busy");
endmodule
`default_nettype wire

@@ hdl/spsw_dp.sv @@
// Datapath for the stroke smoother: window, accumulators, dividers, root,
// width multiply, previous point. Depends on spsw_pkg.
`default_nettype none
module spsw_dp
    import spsw_pkg::*;
#(
    parameter int unsigned MAX_SMOOTHING = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic [3:0]  i_smoothing,
    input  wire logic        i_dynamic_width,
    input  wire logic [11:0] i_base_width,
    input  wire logic [15:0] i_x_pos,
    input  wire logic [15:0] i_y_pos,
    input  wire logic [12:0] i_pressure,
    input  wire logic [31:0] i_timestamp,
    input  wire logic        i_stroke_end,
    output logic             o_emit_any,
    output logic             o_more,
    output t_sts             o_sts,
    output logic [15:0]      o_x,
    output logic [15:0]      o_y,
    output logic [12:0]      o_p,
    output logic [31:0]      o_t,
    output logic [15:0]      o_w,
    output logic             o_last
);
    localparam int unsigned DEPTH = 2 * MAX_SMOOTHING + 1;
    localparam int unsigned DW    = $clog2(DEPTH + 1);
    localparam int unsigned IW    = $clog2(DEPTH);
    localparam int unsigned SW    = $clog2(MAX_SMOOTHING + 1);
    localparam int unsigned WTW   = $clog2((MAX_SMOOTHING + 1) * (MAX_SMOOTHING + 1) + 1);
    localparam int unsigned ACCW  = 16 + WTW + 1;

    // window shift line, newest at tap 0
    logic signed [15:0] r_wx [DEPTH];
    logic signed [15:0] r_wy [DEPTH];
    logic [12:0]        r_wp [DEPTH];
    logic [31:0]        r_wt [DEPTH];
    logic [DW-1:0]      r_cnt;
    logic [SW-1:0]      r_half;
    logic               r_end;
    logic [IW-1:0]      r_e;   // emit offset

    logic [SW-1:0] n_half_cfg;
    assign n_half_cfg = (32'(i_smoothing) > MAX_SMOOTHING) ? SW'(MAX_SMOOTHING)
                                                          : SW'(i_smoothing);

    logic [DW-1:0] n_cnt;
    logic [DW-1:0] w_k;
    always_comb begin
        n_cnt = (r_cnt < DW'(DEPTH)) ? r_cnt + 1'b1 : r_cnt;
        w_k = r_cnt - 1'b1;
    end

    // decide what the incoming point causes (combinational on inputs)
    logic [SW-1:0] w_half_now;
    logic [DW-1:0] w_k_now;
    assign w_half_now = (r_cnt == '0) ? n_half_cfg : r_half;
    assign w_k_now = n_cnt - 1'b1;
    assign o_emit_any = i_stroke_end || (w_k_now >= DW'(w_half_now));
    assign o_more = r_end && (r_e != '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int d = DEPTH - 1; d > 0; d--) begin
                r_wx[d] <= r_wx[d-1];
                r_wy[d] <= r_wy[d-1];
                r_wp[d] <= r_wp[d-1];
                r_wt[d] <= r_wt[d-1];
            end
            r_wx[0] <= i_x_pos;
            r_wy[0] <= i_y_pos;
            r_wp[0] <= i_pressure;
            r_wt[0] <= i_timestamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_half <= '0;
            r_end  <= 1'b0;
            r_e    <= '0;
        end else begin
            if (i_cmd.load) begin
                r_cnt  <= n_cnt;
                r_half <= w_half_now;
                r_end  <= i_stroke_end;
                if (i_stroke_end) begin
                    r_e <= (DW'(w_half_now) < w_k_now) ? IW'(w_half_now) : IW'(w_k_now);
                end else begin
                    r_e <= IW'(w_half_now);
                end
            end else if (i_cmd.out_load && o_more) begin
                r_e <= r_e - 1'b1;
            end
            if (i_cmd.stroke_clr && r_end) begin
                r_cnt <= '0;
            end
        end
    end

    // ---- weighted sum: one tap per cycle, m from -S..S ----
    logic signed [SW+1:0]   r_m;
    logic signed [ACCW-1:0] r_sx, r_sy;
    logic [ACCW-1:0]        r_sp;
    logic [WTW-1:0]         r_tw;
    logic                   r_pass;
    logic signed [SW+1:0]   w_s, w_ie, w_ee, w_d;
    logic [SW:0]            w_absm;
    logic [SW:0]            w_wt;
    logic                   w_tap_ok;
    logic [IW-1:0]          w_didx;
    logic [DW-1:0]          w_i;

    always_comb begin
        w_i    = w_k - DW'(r_e);
        w_s    = (SW+2)'(r_half);
        w_ee   = (SW+2)'(r_e);
        w_ie   = (w_i > DW'(MAX_SMOOTHING)) ? (SW+2)'(MAX_SMOOTHING + 1) : (SW+2)'(w_i);
        w_d    = w_ee - r_m;
        w_absm = r_m[SW+1] ? (SW+1)'(-r_m) : (SW+1)'(r_m);
        w_wt   = (SW+1)'(r_half) + 1'b1 - w_absm;
        w_tap_ok = (r_m >= -w_ie) && (r_m <= w_ee) && !w_d[SW+1]
                   && (w_d < (SW+2)'(DEPTH));
        w_didx = IW'(w_d);
    end

    // done once the last tap (m = S) has landed in the accumulators, or at once when S is 0
    assign o_sts.sum_done = (r_half == '0) || (r_pass && (r_m == w_s + (SW+2)'(1)));

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_clr) begin
            r_m  <= '0;
            r_sx <= '0; r_sy <= '0; r_sp <= '0; r_tw <= '0;
            r_pass <= 1'b0;
        end else if (i_cmd.sum_step) begin
            if (r_m == '0 && o_sts.sum_done == 1'b0 && r_tw == '0 && r_sp == '0
                && r_pass == 1'b0) begin
                r_m <= -w_s;
                r_pass <= 1'b1;
            end else begin
                if (w_tap_ok) begin
                    r_sx <= r_sx + ACCW'(r_wx[w_didx] * $signed({1'b0, w_wt}));
                    r_sy <= r_sy + ACCW'(r_wy[w_didx] * $signed({1'b0, w_wt}));
                    r_sp <= r_sp + ACCW'(r_wp[w_didx] * w_wt);
                    r_tw <= r_tw + WTW'(w_wt);
                end
                r_m <= r_m + 1'b1;
                r_pass <= 1'b1;
            end
        end
    end

    // ---- rounding divide: three quotients, restoring, one bit a cycle ----
    localparam int unsigned QW = ACCW + 1;
    logic [QW-1:0] r_nx, r_ny, r_np, r_qx, r_qy, r_qp;
    logic [QW-1:0] r_rx, r_ry, r_rp;
    logic          r_negx, r_negy;
    logic [WTW:0]  r_dv;
    logic [$clog2(QW+1)-1:0] r_dcnt;
    logic          r_plain;
    logic [QW:0]   w_tx, w_ty, w_tp;
    logic [QW-1:0] w_ux, w_uy;

    assign w_ux = r_sx[ACCW-1] ? QW'(-r_sx) : QW'(r_sx);
    assign w_uy = r_sy[ACCW-1] ? QW'(-r_sy) : QW'(r_sy);
    assign w_tx = {r_rx, r_nx[QW-1]} - (QW+1)'(r_dv);
    assign w_ty = {r_ry, r_ny[QW-1]} - (QW+1)'(r_dv);
    assign w_tp = {r_rp, r_np[QW-1]} - (QW+1)'(r_dv);
    assign o_sts.div_done = r_plain || (r_dcnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_plain <= (w_i == '0) || (r_e == '0) || (r_half == '0);
            r_negx <= r_sx[ACCW-1];
            r_negy <= r_sy[ACCW-1];
            r_nx <= QW'({w_ux, 1'b0}) + QW'(r_tw);
            r_ny <= QW'({w_uy, 1'b0}) + QW'(r_tw);
            r_np <= QW'({r_sp, 1'b0}) + QW'(r_tw);
            r_dv <= {r_tw, 1'b0};
            r_rx <= '0; r_ry <= '0; r_rp <= '0;
            r_qx <= '0; r_qy <= '0; r_qp <= '0;
            r_dcnt <= ($clog2(QW+1))'(QW);
        end else if (i_cmd.div_step && r_dcnt != '0) begin
            r_dcnt <= r_dcnt - 1'b1;
            r_nx <= {r_nx[QW-2:0], 1'b0};
            r_ny <= {r_ny[QW-2:0], 1'b0};
            r_np <= {r_np[QW-2:0], 1'b0};
            r_rx <= w_tx[QW] ? QW'({r_rx, r_nx[QW-1]}) : QW'(w_tx);
            r_ry <= w_ty[QW] ? QW'({r_ry, r_ny[QW-1]}) : QW'(w_ty);
            r_rp <= w_tp[QW] ? QW'({r_rp, r_np[QW-1]}) : QW'(w_tp);
            r_qx <= {r_qx[QW-2:0], !w_tx[QW]};
            r_qy <= {r_qy[QW-2:0], !w_ty[QW]};
            r_qp <= {r_qp[QW-2:0], !w_tp[QW]};
        end
    end

    logic signed [15:0] w_x, w_y;
    logic [12:0]        w_p;
    logic [31:0]        w_t;
    always_comb begin
        w_t = r_wt[r_e];
        if (r_plain) begin
            w_x = r_wx[r_e];
            w_y = r_wy[r_e];
            w_p = r_wp[r_e];
        end else begin
            w_x = r_negx ? 16'(-r_qx) : 16'(r_qx);
            w_y = r_negy ? 16'(-r_qy) : 16'(r_qy);
            w_p = 13'(r_qp);
        end
    end

    // previous emitted point
    logic signed [15:0] r_px, r_py;
    logic [31:0]        r_pt;
    logic               r_pv;
    assign o_sts.need_speed = i_dynamic_width && r_pv && (w_t > r_pt);

    // ---- integer square root, two bits a cycle ----
    logic [33:0] r_sv, r_res, r_bit;
    logic signed [16:0] w_dx, w_dy;
    logic [33:0] w_sum;
    assign w_dx = 17'(w_x) - 17'(r_px);
    assign w_dy = 17'(w_y) - 17'(r_py);
    assign o_sts.sqrt_done = (r_bit == '0);

    // squares registered before the add (one multiplier each)
    logic [33:0] r_dx2, r_dy2;
    logic        r_sq_go;
    assign w_sum = r_dx2 + r_dy2;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_start) begin
            r_dx2 <= $unsigned(34'(w_dx) * 34'(w_dx));
            r_dy2 <= $unsigned(34'(w_dy) * 34'(w_dy));
            r_sq_go <= 1'b1;
            r_bit <= 34'd1 << 32;
            r_res <= '0;
        end else if (i_cmd.sqrt_step) begin
            if (r_sq_go) begin
                r_sv <= w_sum;
                r_sq_go <= 1'b0;
            end else if (r_bit != '0) begin
                if (r_sv >= r_res + r_bit) begin
                    r_sv <= r_sv - (r_res + r_bit);
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
        end
    end

    // ---- factor divide: 102400*dt / dist, quotient capped ----
    logic [48:0] r_fn, r_fr;
    logic [17:0] r_fq;
    logic [16:0] r_dist;
    logic [5:0]  r_fcnt;
    logic        r_fsat;
    logic [49:0] w_ft;
    assign w_ft = {r_fr, r_fn[48]} - 50'(r_dist);
    assign o_sts.fdiv_done = r_fsat || (r_fcnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.fdiv_start) begin
            r_fn <= 49'(w_t - r_pt) * 49'd102400;
            r_dist <= 17'(r_res);
            r_fsat <= (r_res == '0);
            r_fr <= '0;
            r_fq <= '0;
            r_fcnt <= 6'd49;
        end else if (i_cmd.fdiv_step && r_fcnt != '0 && !r_fsat) begin
            r_fcnt <= r_fcnt - 1'b1;
            r_fn <= {r_fn[47:0], 1'b0};
            r_fr <= w_ft[49] ? 49'({r_fr, r_fn[48]}) : 49'(w_ft);
            if (!w_ft[49] && r_fq >= F_MAX) r_fq <= F_MAX;
            else if (r_fq >= F_MAX) r_fq <= F_MAX;
            else r_fq <= {r_fq[16:0], !w_ft[49]};
        end
    end

    logic [17:0] w_f;
    always_comb begin
        if (!o_sts.need_speed) w_f = F_ONE;
        else if (r_fsat || r_fq >= F_MAX) w_f = F_MAX;
        else if (r_fq < F_MIN) w_f = F_MIN;
        else w_f = r_fq;
    end

    // ---- width: two registered multiplies ----
    logic [24:0] r_bp;
    logic [42:0] r_bpf;
    always_ff @(posedge i_clk) begin
        if (i_cmd.wid_mul1) r_bp <= 25'(i_base_width) * 25'(w_p);
        if (i_cmd.wid_mul2) r_bpf <= 43'(r_bp) * 43'(w_f) + (43'd1 << 27);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_px <= '0; r_py <= '0; r_pt <= '0;
        end else if (i_cmd.commit) begin
            r_px <= w_x; r_py <= w_y; r_pt <= w_t;
            r_pv <= !(r_end && !o_more);
        end
    end

    assign o_x = w_x;
    assign o_y = w_y;
    assign o_p = w_p;
    assign o_t = w_t;
    // largest product stays below 2^43, so the width never reaches the 16-bit limit
    assign o_w = {1'b0, r_bpf[42:28]};
    assign o_last = r_end && (r_e == '0);
endmodule
`default_nettype wire

@@ hdl/stroke_point_smoother_width.sv @@
// Stroke point smoother with width: top level, config registers, output word.
// Depends on spsw_pkg, spsw_ctrl, spsw_dp.
// Each word: window sum (no taps when S is 0), rounding divide (done at once for a point that
// passes unchanged), then width, multiply and output states; dynamic mode adds square root and
// factor divide (done at once at zero distance) when the speed factor path is taken.
// Throughput: one point at a time, up to S+1 words on stroke end. Reset: sync active low.
`default_nettype none
module stroke_point_smoother_width
    import spsw_pkg::*;
#(
    parameter int unsigned MAX_SMOOTHING = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [79:0] s_axis_tdata,  // x_pos, y_pos, pressure, timestamp, 3'b0
    input  wire logic        s_axis_tlast,  // stroke_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [95:0]      m_axis_tdata,  // out_x, out_y, out_pressure, out_timestamp,
                                            // out_width, 3'b0
    output logic             m_axis_tlast,  // out_last
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [11:0] i_cfg_data
);
    logic [3:0]  r_smoothing;
    logic        r_dynamic;
    logic [11:0] r_base;

    // config writes land whenever offered; the user must write only while idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smoothing <= '0;
            r_dynamic   <= 1'b0;
            r_base      <= 12'd32;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                2'(IDX_SMOOTHING):     r_smoothing <= i_cfg_data[3:0];
                2'(IDX_DYNAMIC_WIDTH): r_dynamic   <= i_cfg_data[0];
                2'(IDX_BASE_WIDTH):    r_base      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_busy, w_emit_any, w_more, w_in_fire, w_out_free;
    logic [15:0] w_x, w_y, w_w;
    logic [12:0] w_p;
    logic [31:0] w_t;
    logic        w_last;

    assign s_axis_tready = !w_busy;
    assign w_in_fire = s_axis_tvalid && s_axis_tready;
    // output register frees when empty or being taken this cycle
    assign w_out_free = !m_axis_tvalid || m_axis_tready;

    spsw_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(w_in_fire),
        .i_emit_any(w_emit_any), .i_more(w_more), .i_out_free(w_out_free),
        .i_sts(w_sts), .o_cmd(w_cmd), .o_busy(w_busy)
    );

    spsw_dp #(.MAX_SMOOTHING(MAX_SMOOTHING)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_smoothing(r_smoothing), .i_dynamic_width(r_dynamic), .i_base_width(r_base),
        .i_x_pos(s_axis_tdata[15:0]), .i_y_pos(s_axis_tdata[31:16]),
        .i_pressure(s_axis_tdata[44:32]), .i_timestamp(s_axis_tdata[76:45]),
        .i_stroke_end(s_axis_tlast),
        .o_emit_any(w_emit_any), .o_more(w_more), .o_sts(w_sts),
        .o_x(w_x), .o_y(w_y), .o_p(w_p), .o_t(w_t), .o_w(w_w), .o_last(w_last)
    );

    // output register: hold word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (w_cmd.out_load) begin
            m_axis_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.out_load) begin
            m_axis_tdata <= {3'b000, w_w, w_t, w_p, w_y, w_x};
            m_axis_tlast <= w_last;
        end
    end

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("output word dropped");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("stalled word changed");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !w_in_fire)
        else $error("point accepted while busy");
endmodule
`default_nettype wire

@@ sim/stroke_point_smoother_width_tb.sv @@
// Self-checking testbench for stroke_point_smoother_width: directed and random strokes
// under several idle patterns, every word checked against an in-bench smoother model.
// Depends on spsw_pkg and the stroke_point_smoother_width RTL.
`timescale 1ns / 100ps
`default_nettype none
module stroke_point_smoother_width_tb
    import spsw_pkg::*;
();

    localparam int MAX_S = 8;
    localparam int DEPTH = 2 * MAX_S + 1;
    localparam int DRAIN_CYCLES = 300;  // covers sum, divide, root and factor divide

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [12:0]        p;
        logic [31:0]        t;
        logic [15:0]        w;
        logic               last;
    } t_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;   // x_pos, y_pos, pressure, timestamp, 3'b0
    logic        s_axis_tlast;   // stroke_end
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;   // out_x, out_y, out_pressure, out_timestamp, out_width, 3'b0
    logic        m_axis_tlast;   // out_last
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [11:0] i_cfg_data;

    stroke_point_smoother_width i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Model state: shadow config, point window (newest at entry 0), previous word.
    logic [3:0]         cfg_smoothing;
    logic               cfg_dynamic;
    logic [11:0]        cfg_base;
    logic signed [15:0] win_x [DEPTH];
    logic signed [15:0] win_y [DEPTH];
    logic [12:0]        win_p [DEPTH];
    logic [31:0]        win_t [DEPTH];
    int                 stroke_count;
    int                 stroke_half;
    logic signed [15:0] prev_x;
    logic signed [15:0] prev_y;
    logic [31:0]        prev_t;
    logic               prev_valid;

    t_word expected_words [$];
    int    error_count;
    int    sender_idle_pct;
    int    receiver_stall_pct;

    // Stroke generator state, kept across points so strokes look like pen motion.
    int          pen_x;
    int          pen_y;
    logic [31:0] pen_t;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    // Receiver: stall at random with the current stall percentage.
    initial m_axis_tready = 1'b0;
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Divide to nearest, ties away from zero.
    function automatic longint round_div(longint sum, longint wt);
        if (sum >= 0) return (sum * 2 + wt) / (2 * wt);
        return -(((-sum) * 2 + wt) / (2 * wt));
    endfunction

    // Build the word for the point e places older than the newest (k = newest index).
    task automatic smooth_word(input int e, input int k, input int s, input logic last);
        t_word           wd;
        longint          sx, sy, sp, tw, wt, dx, dy;
        longint unsigned span, f, dt, wide;
        int              m, d, i;
        i = k - e;
        sx = 0; sy = 0; sp = 0; tw = 0;
        f = 65536;
        wd.t = win_t[e];
        if (i == 0 || e == 0) begin
            wd.x = win_x[e];
            wd.y = win_y[e];
            wd.p = win_p[e];
        end else begin
            for (m = -s; m <= s; m++) begin
                // clip the window to the stroke on both sides
                if (m >= -i && m <= e) begin
                    d = e - m;
                    wt = s + 1 - ((m < 0) ? -m : m);
                    sx += longint'(win_x[d]) * wt;
                    sy += longint'(win_y[d]) * wt;
                    sp += longint'({1'b0, win_p[d]}) * wt;
                    tw += wt;
                end
            end
            wd.x = 16'(round_div(sx, tw));
            wd.y = 16'(round_div(sy, tw));
            wd.p = 13'(round_div(sp, tw));
        end
        if (cfg_dynamic && prev_valid && wd.t > prev_t) begin
            dt = longint'(wd.t - prev_t);
            dx = longint'(wd.x) - longint'(prev_x);
            dy = longint'(wd.y) - longint'(prev_y);
            span = root64(dx * dx + dy * dy);
            if (span == 0) begin
                f = 131072;
            end else begin
                f = (64'd102400 * dt) / span;
                if (f < 6554) f = 6554;
                if (f > 131072) f = 131072;
            end
        end
        wide = (longint'(cfg_base) * longint'(wd.p) * f + (64'd1 << 27)) >> 28;
        wd.w = (wide > 65535) ? 16'hFFFF : 16'(wide);
        wd.last = last;
        expected_words.insert(expected_words.size(), wd);
        prev_x = wd.x; prev_y = wd.y; prev_t = wd.t; prev_valid = 1'b1;
    endtask

    // Advance the model by one accepted point and queue the words it releases.
    task automatic predict_point(input logic [15:0] x, input logic [15:0] y,
                                 input logic [12:0] p, input logic [31:0] t,
                                 input logic last);
        int k, e;
        if (stroke_count == 0)
            stroke_half = (cfg_smoothing > MAX_S) ? MAX_S : cfg_smoothing;
        for (int d = DEPTH - 1; d > 0; d--) begin
            win_x[d] = win_x[d - 1]; win_y[d] = win_y[d - 1];
            win_p[d] = win_p[d - 1]; win_t[d] = win_t[d - 1];
        end
        win_x[0] = x; win_y[0] = y; win_p[0] = p; win_t[0] = t;
        if (stroke_count < DEPTH) stroke_count++;
        k = stroke_count - 1;
        if (!last) begin
            if (k >= stroke_half) smooth_word(stroke_half, k, stroke_half, 1'b0);
        end else begin
            // flush every pending point, oldest first
            e = (stroke_half < k) ? stroke_half : k;
            while (e >= 0) begin
                smooth_word(e, k, stroke_half, e == 0);
                e--;
            end
            stroke_count = 0;
            prev_valid = 1'b0;
        end
    endtask

    // Send one point, idling first at random; hold valid high across back-to-back words.
    task automatic send_point(input logic [15:0] x, input logic [15:0] y,
                              input logic [12:0] p, input logic [31:0] t,
                              input logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b0, t, p, y, x};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_point(x, y, p, t, last);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write one register; call only once the block has drained.
    task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            2'(IDX_SMOOTHING):     cfg_smoothing = val[3:0];
            2'(IDX_DYNAMIC_WIDTH): cfg_dynamic   = val[0];
            2'(IDX_BASE_WIDTH):    cfg_base      = val;
            default: ;  // unused index, dropped by the block
        endcase
    endtask

    task automatic set_config(input int s, input int dyn, input int base);
        drain();
        write_reg(2'(IDX_SMOOTHING), 12'(s));
        write_reg(2'(IDX_DYNAMIC_WIDTH), 12'(dyn));
        write_reg(2'(IDX_BASE_WIDTH), 12'(base));
    endtask

    // One pen stroke: mostly smooth motion with increasing time, some wild points.
    task automatic random_stroke(input int len);
        logic [12:0] p;
        for (int n = 0; n < len; n++) begin
            if ($urandom_range(9) == 0) begin
                pen_x = $urandom_range(65535);
                pen_y = $urandom_range(65535);
            end else begin
                pen_x += $urandom_range(400) - 200;
                pen_y += $urandom_range(400) - 200;
            end
            case ($urandom_range(19))
                0:       pen_t = $urandom;
                1:       pen_t = pen_t - $urandom_range(50);
                default: pen_t = pen_t + $urandom_range(3000);
            endcase
            p = ($urandom_range(19) == 0) ? 13'($urandom_range(8191)) : 13'($urandom_range(4096));
            send_point(16'(pen_x), 16'(pen_y), p, pen_t, n == len - 1);
        end
    endtask

    // Output checker: compare each word with the oldest expectation.
    always @(posedge i_clk) begin
        t_word wd;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word %h", m_axis_tdata);
                error_count++;
            end else begin
                wd = expected_words.pop_front();
                if (m_axis_tdata[15:0] !== wd.x) begin
                    $error("out_x exp %0d got %0d", wd.x, $signed(m_axis_tdata[15:0]));
                    error_count++;
                end
                if (m_axis_tdata[31:16] !== wd.y) begin
                    $error("out_y exp %0d got %0d", wd.y, $signed(m_axis_tdata[31:16]));
                    error_count++;
                end
                if (m_axis_tdata[44:32] !== wd.p) begin
                    $error("out_pressure exp %0d got %0d", wd.p, m_axis_tdata[44:32]);
                    error_count++;
                end
                if (m_axis_tdata[76:45] !== wd.t) begin
                    $error("out_timestamp exp %0d got %0d", wd.t, m_axis_tdata[76:45]);
                    error_count++;
                end
                if (m_axis_tdata[92:77] !== wd.w) begin
                    $error("out_width exp %0d got %0d", wd.w, m_axis_tdata[92:77]);
                    error_count++;
                end
                if (m_axis_tlast !== wd.last) begin
                    $error("out_last exp %0d got %0d", wd.last, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    // Extremes of every field, pass-through, short strokes, truncated windows.
    task automatic test_directed;
        // smoothing 0: every point straight through, full-scale values
        send_point(16'h7FFF, 16'h8000, 13'd4096, 32'hFFFF_FFFF, 1'b0);
        send_point(16'h8000, 16'h7FFF, 13'd8191, 32'd0, 1'b0);
        send_point(16'hFFFF, 16'h0000, 13'd0, 32'h8000_0000, 1'b1);
        // largest base width, dynamic mode, half-width above the maximum
        set_config(15, 1, 4095);
        send_point(16'd0, 16'd0, 13'd4096, 32'd100, 1'b1);      // single-point stroke
        send_point(16'd10, 16'd10, 13'd2048, 32'd100, 1'b0);
        send_point(16'd10, 16'd10, 13'd2048, 32'd200, 1'b1);    // zero distance
        for (int n = 0; n < 10; n++)
            send_point(16'(n * 3000 - 15000), 16'(-n * 7), 13'(n * 400), 32'(1000 + n * 5),
                       n == 9);
        // tiny base width, fast and slow motion for both factor clamps
        set_config(2, 1, 0);
        write_reg(2'(IDX_BASE_WIDTH), 12'd1);
        write_reg(2'd3, 12'hFFF);                                // unused index
        send_point(16'd0, 16'd0, 13'd4096, 32'd0, 1'b0);
        send_point(16'd8000, 16'd0, 13'd4096, 32'd1, 1'b0);
        // change half-width mid-stroke: takes effect on the next stroke
        drain();
        write_reg(2'(IDX_SMOOTHING), 12'd1);
        send_point(16'd8000, 16'd1, 13'd4096, 32'd900000, 1'b0);
        send_point(16'd8001, 16'd1, 13'd100, 32'd900000, 1'b0);
        send_point(16'd8002, 16'd2, 13'd4096, 32'd899999, 1'b1);
        send_point(16'd5, 16'd5, 13'd1, 32'd5, 1'b0);
        send_point(16'd6, 16'd6, 13'd1, 32'd6, 1'b1);
    endtask

    // Random strokes under random settings, extremes included.
    task automatic test_random(input int idle, input int stall, input int points);
        int sent;
        int len;
        int s;
        int base;
        sender_idle_pct = idle;
        receiver_stall_pct = stall;
        for (int seg = 0; seg < 2; seg++) begin
            s = (seg == 0) ? 8 : $urandom_range(15);
            case ($urandom_range(3))
                0:       base = 4095;
                1:       base = 2;
                default: base = $urandom_range(4095);
            endcase
            set_config(s, $urandom_range(1), base);
            sent = 0;
            while (sent < points / 2) begin
                len = ($urandom_range(9) == 0) ? 1 : $urandom_range(20, 2);
                random_stroke(len);
                sent += len;
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        error_count   = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        cfg_smoothing = 4'd0;
        cfg_dynamic   = 1'b0;
        cfg_base      = 12'd32;
        stroke_count  = 0;
        stroke_half   = 0;
        prev_x = '0; prev_y = '0; prev_t = '0; prev_valid = 1'b0;
        pen_x = 0; pen_y = 0; pen_t = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(0, 0, 120);
        test_random(84, 0, 120);
        test_random(0, 84, 120);
        test_random(23, 23, 120);

        drain();
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
hdl/spsw_pkg.sv
hdl/spsw_ctrl.sv
hdl/spsw_dp.sv
hdl/stroke_point_smoother_width.sv
sim/stroke_point_smoother_width_tb.sv
